### rtl/rlmr_pkg.sv
// ----------------------------------------------------------------------------
// rlmr_pkg
// Shared types and default constants of the run-length mask row table.
// ----------------------------------------------------------------------------
package rlmr_pkg;

   localparam int X_SIZE_DEF   = 1024;
   localparam int Y_SIZE_DEF   = 64;
   localparam int Z_SIZE_DEF   = 64;
   localparam int MAX_RUNS_DEF = 16;

   // fixed field widths of the transaction ports
   localparam int X_W     = 10;
   localparam int COORD_W = 6;
   localparam int RUNS_W  = 5;
   localparam int RUN_W   = 2 * X_W;

   typedef enum logic [1:0] {
      OP_ADD    = 2'd0,
      OP_REMOVE = 2'd1,
      OP_QUERY  = 2'd2,
      OP_CLEAR  = 2'd3
   } op_type;

   typedef enum logic [4:0] {
      ST_IDLE,
      ST_CLR,
      ST_CNT_WAIT,
      ST_PRE_RD,
      ST_PRE_EV,
      ST_ADD_RD,
      ST_ADD_EV,
      ST_ADD_FIN,
      ST_REM_RD,
      ST_REM_EV,
      ST_SHD_RD,
      ST_SHD_WR,
      ST_SHU_RD,
      ST_SHU_WR,
      ST_SPL_WR0,
      ST_SPL_WR1,
      ST_QRY_RD,
      ST_QRY_EV,
      ST_CNT_WR,
      ST_DONE
   } state_type;

endpackage

### rtl/rlmr_ram.sv
// ----------------------------------------------------------------------------
// rlmr_ram
// Simple dual-port synchronous RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module rlmr_ram #(
   parameter int WIDTH = rlmr_pkg::RUN_W,
   parameter int DEPTH = rlmr_pkg::Y_SIZE_DEF * rlmr_pkg::Z_SIZE_DEF,
   localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

### rtl/run_length_mask_row_table_top.sv
// ----------------------------------------------------------------------------
// run_length_mask_row_table_top
// Binary 3-D mask kept as sorted, disjoint x runs per (y,z) row.
// ----------------------------------------------------------------------------
// One transaction at a time. Every run read goes through the single read
// port of the run RAM: each run is addressed in a read state and then
// evaluated in an evaluate state. An add pre-scans a full row first, and a
// remove may shift the runs that follow the one it changes. Clear sweeps
// every row of the run count RAM; the same sweep runs
// after reset, during which no request is taken. A result waits in an output
// register, and the next request is accepted while it is stalled.
module run_length_mask_row_table_top #(
   parameter int X_SIZE   = rlmr_pkg::X_SIZE_DEF,
   parameter int Y_SIZE   = rlmr_pkg::Y_SIZE_DEF,
   parameter int Z_SIZE   = rlmr_pkg::Z_SIZE_DEF,
   parameter int MAX_RUNS = rlmr_pkg::MAX_RUNS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [1:0]                    req_op,
   input  logic [rlmr_pkg::X_W-1:0]      req_x_start,
   input  logic [rlmr_pkg::X_W-1:0]      req_x_end,
   input  logic [rlmr_pkg::COORD_W-1:0]  req_y,
   input  logic [rlmr_pkg::COORD_W-1:0]  req_z,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic                          rsp_inside_res,
   output logic                          rsp_overflow,
   output logic [rlmr_pkg::RUNS_W-1:0]   rsp_runs_in_row
);

   localparam int ROWS  = Y_SIZE * Z_SIZE;
   localparam int ROW_W = (ROWS > 1) ? $clog2(ROWS) : 1;
   localparam int DEPTH = ROWS * MAX_RUNS;
   localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW    = $clog2(MAX_RUNS + 1);
   localparam int XW    = rlmr_pkg::X_W;

   rlmr_pkg::state_type state_ff, state_in;
   rlmr_pkg::op_type    op_ff, op_in;
   logic [XW-1:0]    xs_ff, xs_in, xe_ff, xe_in;
   logic [ROW_W-1:0] row_ff, row_in, clr_ff, clr_in;
   logic [AW-1:0]    base_ff, base_in;
   logic [CW-1:0]    cnt_ff, cnt_in, idx_ff, idx_in, k_ff, k_in, w_ff, w_in;
   logic [CW-1:0]    newcnt_ff, newcnt_in;
   logic             placed_ff, placed_in, merge_ff, merge_in;
   logic             inside_ff, inside_in, ovf_ff, ovf_in;
   logic             clr_rsp_ff, clr_rsp_in;
   logic [XW-1:0]    ms_ff, ms_in, me_ff, me_in, a_ff, a_in, b_ff, b_in;
   logic [XW-1:0]    pend_s_ff, pend_s_in, pend_e_ff, pend_e_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic             rsp_inside_ff, rsp_inside_in, rsp_ovf_ff, rsp_ovf_in;
   logic [CW-1:0]    rsp_cnt_ff, rsp_cnt_in;

   // count ram
   logic             cnt_we;
   logic [ROW_W-1:0] cnt_waddr, cnt_raddr;
   logic [CW-1:0]    cnt_wdata, cnt_q;

   // run ram, start in the upper half, end in the lower half
   logic                          run_we;
   logic [AW-1:0]                 run_waddr, run_raddr;
   logic [rlmr_pkg::RUN_W-1:0]    run_wdata, run_q;
   logic [XW-1:0]                 run_a, run_b;

   logic          accept;
   logic [CW:0]   idx_nx;
   logic          idx_last;
   logic [CW-1:0] cnt_clip;
   logic          xs_ok;
   logic          below_run, above_run;
   logic [ROW_W-1:0] req_row;

   rlmr_ram #(.WIDTH(CW), .DEPTH(ROWS)) u_cnt_ram (
      .clock   (clock),
      .wr_en   (cnt_we),
      .wr_addr (cnt_waddr),
      .wr_data (cnt_wdata),
      .rd_addr (cnt_raddr),
      .rd_data (cnt_q)
   );

   rlmr_ram #(.WIDTH(rlmr_pkg::RUN_W), .DEPTH(DEPTH)) u_run_ram (
      .clock   (clock),
      .wr_en   (run_we),
      .wr_addr (run_waddr),
      .wr_data (run_wdata),
      .rd_addr (run_raddr),
      .rd_data (run_q)
   );

   assign run_a = run_q[rlmr_pkg::RUN_W-1:XW];
   assign run_b = run_q[XW-1:0];

   assign req_stall = (state_ff != rlmr_pkg::ST_IDLE);
   assign accept    = req_valid && !req_stall;
   assign req_row   = ROW_W'(32'(req_z) * Y_SIZE + 32'(req_y));

   assign idx_nx   = {1'b0, idx_ff} + 1'b1;
   assign idx_last = (idx_nx == {1'b0, cnt_ff});
   assign cnt_clip = (32'(cnt_q) > MAX_RUNS) ? CW'(MAX_RUNS) : cnt_q;
   assign xs_ok    = (32'(xs_ff) < X_SIZE);
   // run lies wholly below, or wholly above, the new run without touching it
   assign below_run = (({1'b0, run_b} + 1'b1) < {1'b0, ms_ff});
   assign above_run = ({1'b0, run_a} > ({1'b0, xe_ff} + 1'b1));

   assign cnt_raddr = (state_ff == rlmr_pkg::ST_IDLE) ? req_row : row_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= rlmr_pkg::ST_CLR;
         clr_ff       <= '0;
         clr_rsp_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         clr_rsp_ff   <= clr_rsp_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff         <= op_in;
      xs_ff         <= xs_in;
      xe_ff         <= xe_in;
      row_ff        <= row_in;
      base_ff       <= base_in;
      cnt_ff        <= cnt_in;
      idx_ff        <= idx_in;
      k_ff          <= k_in;
      w_ff          <= w_in;
      newcnt_ff     <= newcnt_in;
      placed_ff     <= placed_in;
      merge_ff      <= merge_in;
      inside_ff     <= inside_in;
      ovf_ff        <= ovf_in;
      ms_ff         <= ms_in;
      me_ff         <= me_in;
      a_ff          <= a_in;
      b_ff          <= b_in;
      pend_s_ff     <= pend_s_in;
      pend_e_ff     <= pend_e_in;
      rsp_inside_ff <= rsp_inside_in;
      rsp_ovf_ff    <= rsp_ovf_in;
      rsp_cnt_ff    <= rsp_cnt_in;
   end

   always_comb begin
      state_in      = state_ff;
      op_in         = op_ff;
      xs_in         = xs_ff;
      xe_in         = xe_ff;
      row_in        = row_ff;
      base_in       = base_ff;
      cnt_in        = cnt_ff;
      idx_in        = idx_ff;
      k_in          = k_ff;
      w_in          = w_ff;
      newcnt_in     = newcnt_ff;
      placed_in     = placed_ff;
      merge_in      = merge_ff;
      inside_in     = inside_ff;
      ovf_in        = ovf_ff;
      ms_in         = ms_ff;
      me_in         = me_ff;
      a_in          = a_ff;
      b_in          = b_ff;
      pend_s_in     = pend_s_ff;
      pend_e_in     = pend_e_ff;
      clr_in        = clr_ff;
      clr_rsp_in    = clr_rsp_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_inside_in = rsp_inside_ff;
      rsp_ovf_in    = rsp_ovf_ff;
      rsp_cnt_in    = rsp_cnt_ff;

      cnt_we    = 1'b0;
      cnt_waddr = row_ff;
      cnt_wdata = newcnt_ff;
      run_we    = 1'b0;
      run_waddr = base_ff + AW'(w_ff);
      run_wdata = {ms_ff, me_ff};
      run_raddr = base_ff + AW'(idx_ff);

      unique case (state_ff)
         rlmr_pkg::ST_IDLE: begin
            if (accept) begin
               op_in     = rlmr_pkg::op_type'(req_op);
               xs_in     = req_x_start;
               xe_in     = (32'(req_x_end) >= X_SIZE) ? XW'(X_SIZE - 1) : req_x_end;
               row_in    = req_row;
               inside_in = 1'b0;
               ovf_in    = 1'b0;
               newcnt_in = '0;
               idx_in    = '0;
               if (rlmr_pkg::op_type'(req_op) == rlmr_pkg::OP_CLEAR) begin
                  clr_in     = '0;
                  clr_rsp_in = 1'b1;
                  state_in   = rlmr_pkg::ST_CLR;
               end else if (32'(req_y) >= Y_SIZE || 32'(req_z) >= Z_SIZE) begin
                  state_in = rlmr_pkg::ST_DONE;
               end else begin
                  state_in = rlmr_pkg::ST_CNT_WAIT;
               end
            end
         end

         rlmr_pkg::ST_CLR: begin
            cnt_we    = 1'b1;
            cnt_waddr = clr_ff;
            cnt_wdata = '0;
            clr_in    = clr_ff + 1'b1;
            if (32'(clr_ff) == ROWS - 1) begin
               clr_rsp_in = 1'b0;
               state_in   = clr_rsp_ff ? rlmr_pkg::ST_DONE : rlmr_pkg::ST_IDLE;
            end
         end

         rlmr_pkg::ST_CNT_WAIT: begin
            base_in   = AW'(32'(row_ff) * MAX_RUNS);
            cnt_in    = cnt_clip;
            newcnt_in = cnt_clip;
            ms_in     = xs_ff;
            me_in     = xe_ff;
            w_in      = '0;
            placed_in = 1'b0;
            merge_in  = 1'b0;
            if (!xs_ok) begin
               state_in = rlmr_pkg::ST_DONE;
            end else begin
               unique case (op_ff)
                  rlmr_pkg::OP_ADD: begin
                     if (xs_ff > xe_ff) begin
                        state_in = rlmr_pkg::ST_DONE;
                     end else if (32'(cnt_clip) == MAX_RUNS) begin
                        state_in = rlmr_pkg::ST_PRE_RD;
                     end else if (cnt_clip == '0) begin
                        state_in = rlmr_pkg::ST_ADD_FIN;
                     end else begin
                        state_in = rlmr_pkg::ST_ADD_RD;
                     end
                  end
                  rlmr_pkg::OP_REMOVE: begin
                     state_in = (cnt_clip == '0) ? rlmr_pkg::ST_DONE : rlmr_pkg::ST_REM_RD;
                  end
                  rlmr_pkg::OP_QUERY: begin
                     state_in = (cnt_clip == '0) ? rlmr_pkg::ST_DONE : rlmr_pkg::ST_QRY_RD;
                  end
                  default: begin
                     state_in = rlmr_pkg::ST_DONE;
                  end
               endcase
            end
         end

         // full row: an add only fits if it merges with some stored run
         rlmr_pkg::ST_PRE_RD: begin
            state_in = rlmr_pkg::ST_PRE_EV;
         end

         rlmr_pkg::ST_PRE_EV: begin
            merge_in = merge_ff || (!below_run && !above_run);
            idx_in   = CW'(idx_nx);
            if (idx_last) begin
               idx_in = '0;
               if (!(merge_ff || (!below_run && !above_run))) begin
                  ovf_in   = 1'b1;
                  state_in = rlmr_pkg::ST_DONE;
               end else begin
                  state_in = rlmr_pkg::ST_ADD_RD;
               end
            end else begin
               state_in = rlmr_pkg::ST_PRE_RD;
            end
         end

         rlmr_pkg::ST_ADD_RD: begin
            state_in = rlmr_pkg::ST_ADD_EV;
         end

         // one write per run that is not merged; a run displaced by the new one waits in pend
         rlmr_pkg::ST_ADD_EV: begin
            if (placed_ff) begin
               run_we    = 1'b1;
               run_wdata = {pend_s_ff, pend_e_ff};
               w_in      = w_ff + 1'b1;
               pend_s_in = run_a;
               pend_e_in = run_b;
            end else if (below_run) begin
               run_we    = 1'b1;
               run_wdata = run_q;
               w_in      = w_ff + 1'b1;
            end else if (above_run) begin
               run_we    = 1'b1;
               w_in      = w_ff + 1'b1;
               placed_in = 1'b1;
               pend_s_in = run_a;
               pend_e_in = run_b;
            end else begin
               if (run_a < ms_ff) ms_in = run_a;
               if (run_b > me_ff) me_in = run_b;
            end
            idx_in   = CW'(idx_nx);
            state_in = idx_last ? rlmr_pkg::ST_ADD_FIN : rlmr_pkg::ST_ADD_RD;
         end

         rlmr_pkg::ST_ADD_FIN: begin
            run_we    = 1'b1;
            run_wdata = placed_ff ? {pend_s_ff, pend_e_ff} : {ms_ff, me_ff};
            newcnt_in = w_ff + 1'b1;
            state_in  = rlmr_pkg::ST_CNT_WR;
         end

         rlmr_pkg::ST_REM_RD: begin
            state_in = rlmr_pkg::ST_REM_EV;
         end

         rlmr_pkg::ST_REM_EV: begin
            a_in = run_a;
            b_in = run_b;
            run_waddr = base_ff + AW'(idx_ff);
            if (xs_ff >= run_a && xs_ff <= run_b) begin
               if (run_a == run_b) begin
                  newcnt_in = cnt_ff - 1'b1;
                  state_in  = idx_last ? rlmr_pkg::ST_CNT_WR : rlmr_pkg::ST_SHD_RD;
               end else if (xs_ff == run_a) begin
                  run_we    = 1'b1;
                  run_wdata = {run_a + 1'b1, run_b};
                  state_in  = rlmr_pkg::ST_DONE;
               end else if (xs_ff == run_b) begin
                  run_we    = 1'b1;
                  run_wdata = {run_a, run_b - 1'b1};
                  state_in  = rlmr_pkg::ST_DONE;
               end else if (32'(cnt_ff) >= MAX_RUNS) begin
                  ovf_in   = 1'b1;
                  state_in = rlmr_pkg::ST_DONE;
               end else begin
                  k_in     = cnt_ff;
                  state_in = ({1'b0, cnt_ff} > idx_nx) ? rlmr_pkg::ST_SHU_RD
                                                       : rlmr_pkg::ST_SPL_WR0;
               end
            end else begin
               idx_in   = CW'(idx_nx);
               state_in = idx_last ? rlmr_pkg::ST_DONE : rlmr_pkg::ST_REM_RD;
            end
         end

         // close the gap left by a deleted single-point run
         rlmr_pkg::ST_SHD_RD: begin
            run_raddr = base_ff + AW'(idx_nx);
            state_in  = rlmr_pkg::ST_SHD_WR;
         end

         rlmr_pkg::ST_SHD_WR: begin
            run_we    = 1'b1;
            run_waddr = base_ff + AW'(idx_ff);
            run_wdata = run_q;
            idx_in    = CW'(idx_nx);
            state_in  = ((idx_nx + 1'b1) < {1'b0, cnt_ff}) ? rlmr_pkg::ST_SHD_RD
                                                           : rlmr_pkg::ST_CNT_WR;
         end

         // open a slot above the run being split, from the top down
         rlmr_pkg::ST_SHU_RD: begin
            run_raddr = base_ff + AW'(k_ff - 1'b1);
            state_in  = rlmr_pkg::ST_SHU_WR;
         end

         rlmr_pkg::ST_SHU_WR: begin
            run_we    = 1'b1;
            run_waddr = base_ff + AW'(k_ff);
            run_wdata = run_q;
            k_in      = k_ff - 1'b1;
            state_in  = ({1'b0, k_ff} - 1'b1 > idx_nx) ? rlmr_pkg::ST_SHU_RD
                                                       : rlmr_pkg::ST_SPL_WR0;
         end

         rlmr_pkg::ST_SPL_WR0: begin
            run_we    = 1'b1;
            run_waddr = base_ff + AW'(idx_ff);
            run_wdata = {a_ff, xs_ff - 1'b1};
            state_in  = rlmr_pkg::ST_SPL_WR1;
         end

         rlmr_pkg::ST_SPL_WR1: begin
            run_we    = 1'b1;
            run_waddr = base_ff + AW'(idx_nx);
            run_wdata = {xs_ff + 1'b1, b_ff};
            newcnt_in = cnt_ff + 1'b1;
            state_in  = rlmr_pkg::ST_CNT_WR;
         end

         rlmr_pkg::ST_QRY_RD: begin
            state_in = rlmr_pkg::ST_QRY_EV;
         end

         rlmr_pkg::ST_QRY_EV: begin
            if (xs_ff >= run_a && xs_ff <= run_b) inside_in = 1'b1;
            idx_in   = CW'(idx_nx);
            state_in = idx_last ? rlmr_pkg::ST_DONE : rlmr_pkg::ST_QRY_RD;
         end

         rlmr_pkg::ST_CNT_WR: begin
            cnt_we   = 1'b1;
            state_in = rlmr_pkg::ST_DONE;
         end

         rlmr_pkg::ST_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in  = 1'b1;
               rsp_inside_in = inside_ff;
               rsp_ovf_in    = ovf_ff;
               rsp_cnt_in    = newcnt_ff;
               state_in      = rlmr_pkg::ST_IDLE;
            end
         end

         default: begin
            state_in = rlmr_pkg::ST_IDLE;
         end
      endcase
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_inside_res  = rsp_inside_ff;
   assign rsp_overflow    = rsp_ovf_ff;
   assign rsp_runs_in_row = rlmr_pkg::RUNS_W'(rsp_cnt_ff);

endmodule

### tb/sv/run_length_mask_row_table_top_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// run_length_mask_row_table_top_tb
// Drives add, remove, query and clear transactions into the row table, with
// random gaps and output stalls. Every result is checked against a run list
// kept per row inside the bench.
// ----------------------------------------------------------------------------
module run_length_mask_row_table_top_tb;

   localparam int ROWS     = rlmr_pkg::Y_SIZE_DEF * rlmr_pkg::Z_SIZE_DEF;
   localparam int RUNS_MAX = rlmr_pkg::MAX_RUNS_DEF;
   localparam int X_LIMIT  = rlmr_pkg::X_SIZE_DEF;

   typedef struct packed {
      rlmr_pkg::op_type             op;
      logic [rlmr_pkg::X_W-1:0]     xs;
      logic [rlmr_pkg::X_W-1:0]     xe;
      logic [rlmr_pkg::COORD_W-1:0] y;
      logic [rlmr_pkg::COORD_W-1:0] z;
   } mask_op_type;

   typedef struct packed {
      logic                        in_run;
      logic                        ovf;
      logic [rlmr_pkg::RUNS_W-1:0] runs;
   } row_rsp_type;

   logic                          clock = 1'b0;
   logic                          reset = 1'b1;
   logic                          req_valid = 1'b0;
   logic                          req_stall;
   logic [1:0]                    req_op = rlmr_pkg::OP_QUERY;
   logic [rlmr_pkg::X_W-1:0]      req_x_start = '0;
   logic [rlmr_pkg::X_W-1:0]      req_x_end = '0;
   logic [rlmr_pkg::COORD_W-1:0]  req_y = '0;
   logic [rlmr_pkg::COORD_W-1:0]  req_z = '0;
   logic                          rsp_valid;
   logic                          rsp_stall = 1'b0;
   logic                          rsp_inside_res;
   logic                          rsp_overflow;
   logic [rlmr_pkg::RUNS_W-1:0]   rsp_runs_in_row;

   mask_op_type pending_ops[$];
   row_rsp_type expected_rsp[$];

   // run lists of the mask, one per (y,z) row
   int run_lo[ROWS][RUNS_MAX];
   int run_hi[ROWS][RUNS_MAX];
   int run_cnt[ROWS];

   int mismatches = 0;
   int accepted = 0;
   int gap_left = 0;
   int stall_left = 0;
   int hold_left = 0;
   bit hold_done = 1'b0;
   bit quiet = 1'b0;

   run_length_mask_row_table_top dut (.*);

   initial begin
      forever #5 clock = ~clock;
   end

   function automatic row_rsp_type mask_predict(mask_op_type t);
      row_rsp_type r;
      int row, cnt, n, ms, me, e, a, b, x, k;
      int ns[RUNS_MAX+1];
      int ne[RUNS_MAX+1];
      bit placed, ovf, hit, done;
      r = '0;
      if (t.op == rlmr_pkg::OP_CLEAR) begin
         foreach (run_cnt[i]) run_cnt[i] = 0;
         return r;
      end
      row = int'(t.z) * rlmr_pkg::Y_SIZE_DEF + int'(t.y);
      cnt = run_cnt[row];
      ovf = 1'b0;
      hit = 1'b0;
      x = int'(t.xs);
      if (t.op == rlmr_pkg::OP_ADD) begin
         e = (int'(t.xe) >= X_LIMIT) ? X_LIMIT - 1 : int'(t.xe);
         me = e;
         ms = x;
         if (ms <= me) begin
            n = 0;
            placed = 1'b0;
            done = 1'b0;
            for (int i = 0; i < cnt && !done; i++) begin
               a = run_lo[row][i];
               b = run_hi[row][i];
               if (b + 1 < x) begin
                  ns[n] = a; ne[n] = b; n++;
               end else if (a > e + 1) begin
                  if (!placed) begin
                     ns[n] = ms; ne[n] = me; n++;
                     placed = 1'b1;
                  end
                  if (n > RUNS_MAX) begin
                     ovf = 1'b1;
                     done = 1'b1;
                  end else begin
                     ns[n] = a; ne[n] = b; n++;
                  end
               end else begin
                  if (a < ms) ms = a;
                  if (b > me) me = b;
               end
            end
            if (!ovf && !placed) begin
               ns[n] = ms; ne[n] = me; n++;
            end
            if (!ovf && n > RUNS_MAX) ovf = 1'b1;
            if (!ovf) begin
               for (int i = 0; i < n; i++) begin
                  run_lo[row][i] = ns[i];
                  run_hi[row][i] = ne[i];
               end
               cnt = n;
            end
         end
      end else if (t.op == rlmr_pkg::OP_REMOVE) begin
         done = 1'b0;
         for (int i = 0; i < cnt && !done; i++) begin
            a = run_lo[row][i];
            b = run_hi[row][i];
            if (x >= a && x <= b) begin
               done = 1'b1;
               if (a == b) begin
                  for (k = i; k + 1 < cnt; k++) begin
                     run_lo[row][k] = run_lo[row][k+1];
                     run_hi[row][k] = run_hi[row][k+1];
                  end
                  cnt--;
               end else if (x == a) begin
                  run_lo[row][i] = a + 1;
               end else if (x == b) begin
                  run_hi[row][i] = b - 1;
               end else if (cnt >= RUNS_MAX) begin
                  ovf = 1'b1;
               end else begin
                  for (k = cnt; k > i + 1; k--) begin
                     run_lo[row][k] = run_lo[row][k-1];
                     run_hi[row][k] = run_hi[row][k-1];
                  end
                  run_hi[row][i] = x - 1;
                  run_lo[row][i+1] = x + 1;
                  run_hi[row][i+1] = b;
                  cnt++;
               end
            end
         end
      end else begin
         for (int i = 0; i < cnt; i++)
            if (x >= run_lo[row][i] && x <= run_hi[row][i]) hit = 1'b1;
      end
      run_cnt[row] = cnt;
      r.in_run = hit;
      r.ovf = ovf;
      r.runs = cnt[rlmr_pkg::RUNS_W-1:0];
      return r;
   endfunction

   task automatic push_op(rlmr_pkg::op_type op, int xs, int xe, int y, int z);
      mask_op_type t;
      t.op = op;
      t.xs = xs[rlmr_pkg::X_W-1:0];
      t.xe = xe[rlmr_pkg::X_W-1:0];
      t.y = y[rlmr_pkg::COORD_W-1:0];
      t.z = z[rlmr_pkg::COORD_W-1:0];
      pending_ops.insert(pending_ops.size(), t);
   endtask

   // stimulus
   initial begin
      int hot_y[4];
      int hot_z[4];
      int y, z, xs, pick;
      foreach (run_cnt[i]) run_cnt[i] = 0;
      push_op(rlmr_pkg::OP_ADD, 0, 0, 0, 0);
      push_op(rlmr_pkg::OP_ADD, 1023, 1023, 0, 0);
      push_op(rlmr_pkg::OP_ADD, 1, 1022, 0, 0);     // touches both ends, merges to one run
      push_op(rlmr_pkg::OP_ADD, 600, 500, 1, 0);    // reversed, ignored
      push_op(rlmr_pkg::OP_QUERY, 512, 0, 0, 0);
      push_op(rlmr_pkg::OP_REMOVE, 512, 0, 0, 0);   // split
      push_op(rlmr_pkg::OP_REMOVE, 0, 0, 0, 0);     // trim start
      push_op(rlmr_pkg::OP_REMOVE, 1023, 0, 0, 0);  // trim end
      push_op(rlmr_pkg::OP_REMOVE, 512, 0, 0, 0);   // point not stored
      push_op(rlmr_pkg::OP_QUERY, 511, 0, 0, 0);
      push_op(rlmr_pkg::OP_QUERY, 512, 0, 0, 0);
      push_op(rlmr_pkg::OP_ADD, 7, 7, 63, 63);
      push_op(rlmr_pkg::OP_REMOVE, 7, 0, 63, 63);   // single point run removed
      push_op(rlmr_pkg::OP_ADD, 341, 682, 42, 21);
      push_op(rlmr_pkg::OP_ADD, 300, 340, 42, 21);  // adjacent on the left
      push_op(rlmr_pkg::OP_QUERY, 1023, 1023, 21, 42);
      push_op(rlmr_pkg::OP_CLEAR, 0, 0, 0, 0);
      push_op(rlmr_pkg::OP_QUERY, 400, 0, 42, 21);
      for (int i = 0; i < 4; i++) begin
         hot_y[i] = $urandom_range(0, 63);
         hot_z[i] = $urandom_range(0, 63);
      end
      for (int i = 0; i < 850; i++) begin
         pick = $urandom_range(0, 3);
         if ($urandom_range(0, 9) < 8) begin
            y = hot_y[pick];
            z = hot_z[pick];
         end else begin
            y = $urandom_range(0, 63);
            z = $urandom_range(0, 63);
         end
         xs = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 1023) : $urandom_range(0, 127);
         pick = $urandom_range(0, 99);
         if (pick < 1)
            push_op(rlmr_pkg::OP_CLEAR, $urandom, $urandom, $urandom, $urandom);
         else if (pick < 45)
            push_op(rlmr_pkg::OP_ADD, xs,
                    ($urandom_range(0, 19) == 0) ? $urandom_range(0, 1023)
                                                 : xs + $urandom_range(0, 4),
                    y, z);
         else if (pick < 72)
            push_op(rlmr_pkg::OP_REMOVE, xs, $urandom, y, z);
         else
            push_op(rlmr_pkg::OP_QUERY, xs, $urandom, y, z);
      end
      repeat (2) @(posedge clock);
      reset <= 1'b0;
   end

   // driver
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && !req_stall) begin
            expected_rsp.insert(expected_rsp.size(),
                                mask_predict({rlmr_pkg::op_type'(req_op), req_x_start,
                                              req_x_end, req_y, req_z}));
            accepted <= accepted + 1;
         end
         if (!req_valid || !req_stall) begin
            if (gap_left > 0) begin
               gap_left <= gap_left - 1;
               req_valid <= 1'b0;
            end else if (pending_ops.size() > 0) begin
               mask_op_type t;
               t = pending_ops.pop_front();
               req_valid <= 1'b1;
               req_op <= t.op;
               req_x_start <= t.xs;
               req_x_end <= t.xe;
               req_y <= t.y;
               req_z <= t.z;
               if (!quiet && $urandom_range(0, 15) == 0) gap_left <= $urandom_range(1, 19);
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin
      quiet <= (pending_ops.size() < 120);
   end

   // long receiver hold-off once 300 transactions have been accepted
   always @(posedge clock) begin
      if (!reset) begin
         if (hold_left > 0)
            hold_left <= hold_left - 1;
         else if (!hold_done && accepted == 300) begin
            hold_left <= 400;
            hold_done <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (hold_left > 0) begin
         rsp_stall <= 1'b1;
      end else if (stall_left > 0) begin
         stall_left <= stall_left - 1;
         rsp_stall <= 1'b1;
      end else if (!quiet && $urandom_range(0, 11) == 0) begin
         stall_left <= $urandom_range(0, 18);
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   // monitor
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_rsp.size() == 0) begin
            mismatches <= mismatches + 1;
            if (mismatches < 10)
               $display("unexpected transaction: inside %0b overflow %0b runs %0d",
                        rsp_inside_res, rsp_overflow, rsp_runs_in_row);
         end else begin
            row_rsp_type e;
            e = expected_rsp.pop_front();
            if (e.in_run !== rsp_inside_res || e.ovf !== rsp_overflow
                || e.runs !== rsp_runs_in_row) begin
               mismatches <= mismatches + 1;
               if (mismatches < 10)
                  $display("mismatch: expected inside %0b overflow %0b runs %0d, got %0b %0b %0d",
                           e.in_run, e.ovf, e.runs,
                           rsp_inside_res, rsp_overflow, rsp_runs_in_row);
            end
         end
      end
   end

   initial begin
      @(negedge reset);
      wait (pending_ops.size() == 0 && !req_valid && expected_rsp.size() == 0);
      repeat (200) @(posedge clock);
      if (mismatches == 0 && expected_rsp.size() == 0)
         $display("run_length_mask_row_table_top verification clean");
      else
         $display("run_length_mask_row_table_top verification failed");
      $finish;
   end

   initial begin
      #20ms;
      $display("run_length_mask_row_table_top verification failed");
      $finish;
   end

endmodule
